// ----- sv/pid_throttle_controller_defines.svh -----
// ----------------------------------------------------------------------------
// pid_throttle_controller_defines
// assertion macros shared by the throttle controller rtl
// ----------------------------------------------------------------------------
`ifndef PID_THROTTLE_CONTROLLER_DEFINES_SVH
`define PID_THROTTLE_CONTROLLER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define PTC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ptc assertion failed");

// next-cycle implication
`define PTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ptc assertion failed");

`else

`define PTC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define PTC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- sv/ptc_pkg.sv -----
// ----------------------------------------------------------------------------
// ptc_pkg
// widths, register codes, reset values and shared types of the controller
// ----------------------------------------------------------------------------
package ptc_pkg;

   // field widths
   localparam int TGT_W      = 19;
   localparam int RPM_W      = 19;
   localparam int GAIN_W     = 24;
   localparam int TS_W       = 16;
   localparam int LIM_W      = 16;
   localparam int CMD_W      = 16;

   // datapath widths
   localparam int ERR_W      = 21;
   localparam int DIFF_W     = 22;
   localparam int INT_W      = 37;
   localparam int ACC_W      = 38;
   localparam int MA_W       = 25;
   localparam int MB_W       = 22;
   localparam int PROD_W     = MA_W + MB_W;
   localparam int SUM_W      = 63;

   // fixed point positions
   localparam int INT_FRAC   = 20;
   localparam int INT_SPLIT  = 18;
   localparam int GAIN_FRAC  = 16;
   localparam int OUT_SHIFT  = 21;
   localparam int SUM_ONE_BIT = 36;

   localparam logic [CMD_W-1:0] OUT_FULL = 16'd32768;

   // configuration port
   localparam int IDX_W      = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [IDX_W-1:0] REG_TARGET = 3'd0;
   localparam logic [IDX_W-1:0] REG_KP     = 3'd1;
   localparam logic [IDX_W-1:0] REG_KI     = 3'd2;
   localparam logic [IDX_W-1:0] REG_KD     = 3'd3;
   localparam logic [IDX_W-1:0] REG_TS     = 3'd4;
   localparam logic [IDX_W-1:0] REG_LIMIT  = 3'd5;

   // register reset values
   localparam logic [TGT_W-1:0]  RST_TARGET = 19'd0;
   localparam logic [GAIN_W-1:0] RST_KP     = 24'd131072;
   localparam logic [GAIN_W-1:0] RST_KI     = 24'd13107;
   localparam logic [GAIN_W-1:0] RST_KD     = 24'd196608;
   localparam logic [TS_W-1:0]   RST_TS     = 16'd1092;
   localparam logic [LIM_W-1:0]  RST_LIMIT  = 16'd500;

   // register file contents as seen by the datapath
   typedef struct packed {
      logic [TGT_W-1:0]  target;
      logic [GAIN_W-1:0] kp;
      logic [GAIN_W-1:0] ki;
      logic [GAIN_W-1:0] kd;
      logic [TS_W-1:0]   time_step;
      logic [LIM_W-1:0]  limit;
      logic              clear_integral;
   } cfg_type;

   // sequencer states
   typedef enum logic [7:0] {
      ST_IDLE      = 8'b0000_0001,
      ST_INT_MUL   = 8'b0000_0010,
      ST_INT_CLAMP = 8'b0000_0100,
      ST_P_ADD     = 8'b0000_1000,
      ST_D_ADD     = 8'b0001_0000,
      ST_IH_ADD    = 8'b0010_0000,
      ST_IL_ADD    = 8'b0100_0000,
      ST_OUT       = 8'b1000_0000
   } state_type;

endpackage

// ----- sv/ptc_channels.sv -----
// ----------------------------------------------------------------------------
// ptc_channels
// valid/ready channel interfaces for samples, commands and register writes
// ----------------------------------------------------------------------------

// speed sample channel
interface ptc_req_if import ptc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [RPM_W-1:0] measured_rpm;

   modport source (output valid, output measured_rpm, input ready);
   modport sink   (input valid, input measured_rpm, output ready);
endinterface

// throttle command channel
interface ptc_rsp_if import ptc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] throttle_cmd;

   modport source (output valid, output throttle_cmd, input ready);
   modport sink   (input valid, input throttle_cmd, output ready);
endinterface

// register write channel
interface ptc_csr_if import ptc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [IDX_W-1:0]      index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/pid_throttle_controller.sv -----
// ----------------------------------------------------------------------------
// pid_throttle_controller
// pid speed governor turning speed samples into throttle commands
// ----------------------------------------------------------------------------
// req_chan carries one measured speed sample per item; rsp_chan returns one
// throttle command (q1.15, 0 to 32768) per sample. csr_chan writes the six
// registers by index: target, kp, ki, kd per step, time step, integral limit.
// Registers must be written only while no sample is in flight; the block
// does not enforce this. A sample passes through int_mul, int_clamp, p_add,
// d_add, ih_add, il_add and out before its command reaches rsp_chan: one
// multiplier is shared by the integral update and the four gain products,
// one product per cycle, each summed in the cycle after it is formed.
// req_chan.ready is high only while the sequencer is idle, so a sample waits
// for the last to leave. A zero target yields command 0 and no state changes.
// Reset restores the default gains, clears the integral and the previous
// error, and empties the output register. The command waits in the output
// register while rsp_chan is stalled; a new sample can still be accepted,
// and its command is held in the sequencer until the register is free.
// ----------------------------------------------------------------------------
`include "pid_throttle_controller_defines.svh"

module pid_throttle_controller import ptc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   ptc_req_if.sink    req_chan,
   ptc_rsp_if.source  rsp_chan,
   ptc_csr_if.sink    csr_chan
);

   cfg_type                  cfg;
   state_type                state_ff, state_in;
   logic signed [ERR_W-1:0]  err_ff, err_in;
   logic signed [ERR_W-1:0]  prev_ff, prev_in;
   logic signed [INT_W-1:0]  integ_ff, integ_in;
   logic                     first_ff, first_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CMD_W-1:0]         rsp_cmd_ff, rsp_cmd_in;
   logic signed [MA_W-1:0]   mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [SUM_W-1:0]  prod_ext;
   logic signed [SUM_W-1:0]  addend;
   logic signed [ACC_W-1:0]  acc;
   logic signed [ACC_W-1:0]  lim_s;
   logic signed [DIFF_W-1:0] diff;
   logic [CMD_W-1:0]         cmd_sat;
   logic                     accept;
   logic                     slot_free;

   ptc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   ptc_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   // handshakes
   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign accept             = req_chan.valid && req_chan.ready;
   assign slot_free          = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.throttle_cmd = rsp_cmd_ff;

   // integral update with symmetric clamp
   assign lim_s = signed'({2'b00, cfg.limit, {INT_FRAC{1'b0}}});
   assign acc   = ACC_W'(integ_ff) + ACC_W'(prod_ff);
   assign diff  = DIFF_W'(err_ff) - DIFF_W'(prev_ff);

   // multiplier operand select
   always_comb begin
      mul_a = signed'({1'b0, cfg.kp});
      mul_b = MB_W'(err_ff);
      case (state_ff)
         ST_INT_MUL: begin
            mul_a = signed'({{(MA_W-TS_W){1'b0}}, cfg.time_step});
            mul_b = MB_W'(err_ff);
         end
         ST_INT_CLAMP: begin
            mul_a = signed'({1'b0, cfg.kp});
            mul_b = MB_W'(err_ff);
         end
         ST_P_ADD: begin
            mul_a = signed'({1'b0, cfg.kd});
            mul_b = MB_W'(diff);
         end
         ST_D_ADD: begin
            mul_a = signed'({1'b0, cfg.ki});
            mul_b = MB_W'(signed'(integ_ff[INT_W-1:INT_SPLIT]));
         end
         ST_IH_ADD: begin
            mul_a = signed'({1'b0, cfg.ki});
            mul_b = signed'({{(MB_W-INT_SPLIT){1'b0}}, integ_ff[INT_SPLIT-1:0]});
         end
         default: ;
      endcase
   end

   // alignment of each product in the sum
   assign prod_ext = SUM_W'(prod_ff);
   always_comb begin
      case (state_ff)
         ST_P_ADD:  addend = prod_ext <<< GAIN_FRAC;
         ST_D_ADD:  addend = prod_ext <<< GAIN_FRAC;
         ST_IH_ADD: addend = prod_ext <<< INT_SPLIT;
         ST_IL_ADD: addend = prod_ext;
         default:   addend = '0;
      endcase
   end

   // output saturation to [0, 1]
   always_comb begin
      if (sum_ff <= 0) begin
         cmd_sat = '0;
      end else if (sum_ff[SUM_W-2:SUM_ONE_BIT] != '0) begin
         cmd_sat = OUT_FULL;
      end else begin
         cmd_sat = {1'b0, sum_ff[OUT_SHIFT+CMD_W-2:OUT_SHIFT]};
      end
   end

   // sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      err_in       = err_ff;
      prev_in      = prev_ff;
      integ_in     = integ_ff;
      first_in     = first_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_cmd_in   = rsp_cmd_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (cfg.target == '0) begin
                  sum_in   = '0;
                  state_in = ST_OUT;
               end else begin
                  err_in   = signed'({2'b00, cfg.target}) -
                             signed'({2'b00, req_chan.measured_rpm});
                  if (first_ff) begin
                     integ_in = '0;
                     first_in = 1'b0;
                  end
                  state_in = ST_INT_MUL;
               end
            end
         end
         ST_INT_MUL: begin
            state_in = ST_INT_CLAMP;
         end
         ST_INT_CLAMP: begin
            if (acc > lim_s) begin
               integ_in = INT_W'(lim_s);
            end else if (acc < -lim_s) begin
               integ_in = INT_W'(-lim_s);
            end else begin
               integ_in = INT_W'(acc);
            end
            sum_in   = '0;
            state_in = ST_P_ADD;
         end
         ST_P_ADD: begin
            sum_in   = sum_ff + addend;
            state_in = ST_D_ADD;
         end
         ST_D_ADD: begin
            sum_in   = sum_ff + addend;
            prev_in  = err_ff;
            state_in = ST_IH_ADD;
         end
         ST_IH_ADD: begin
            sum_in   = sum_ff + addend;
            state_in = ST_IL_ADD;
         end
         ST_IL_ADD: begin
            sum_in   = sum_ff + addend;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_cmd_in   = cmd_sat;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // a target write clears the integral
      if (cfg.clear_integral) begin
         integ_in = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_ff      <= '0;
         integ_ff     <= '0;
         first_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         integ_ff     <= integ_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      err_ff     <= err_in;
      sum_ff     <= sum_in;
      rsp_cmd_ff <= rsp_cmd_in;
   end

   // integral stays inside the limit right after the clamp
   `PTC_ASSERT_IMPLY(a_integ_in_limit, clock, reset, state_ff == ST_P_ADD, (integ_ff <= lim_s) && (integ_ff >= -lim_s))
   // a held command never exceeds full throttle
   `PTC_ASSERT_IMPLY(a_cmd_range, clock, reset, rsp_valid_ff, rsp_cmd_ff <= OUT_FULL)
   // a controlled sample starts the integral multiply
   `PTC_ASSERT_NEXT(a_start_seq, clock, reset, accept && (cfg.target != '0), state_ff == ST_INT_MUL)
   // previous error follows the current error once per sample
   `PTC_ASSERT_NEXT(a_prev_update, clock, reset, state_ff == ST_D_ADD, prev_ff == $past(err_ff))

endmodule

// ----- sv/ptc_csr.sv -----
// ----------------------------------------------------------------------------
// ptc_csr
// configuration registers; a target write also flags an integral clear
// ----------------------------------------------------------------------------
module ptc_csr import ptc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ptc_csr_if.sink   csr_chan,
   output cfg_type   cfg
);

   logic [TGT_W-1:0]  target_ff;
   logic [GAIN_W-1:0] kp_ff;
   logic [GAIN_W-1:0] ki_ff;
   logic [GAIN_W-1:0] kd_ff;
   logic [TS_W-1:0]   ts_ff;
   logic [LIM_W-1:0]  limit_ff;
   logic              wr;

   // writes are always taken
   assign csr_chan.ready = 1'b1;
   assign wr = csr_chan.valid;

   // register writes, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= RST_TARGET;
         kp_ff     <= RST_KP;
         ki_ff     <= RST_KI;
         kd_ff     <= RST_KD;
         ts_ff     <= RST_TS;
         limit_ff  <= RST_LIMIT;
      end else if (wr) begin
         case (csr_chan.index)
            REG_TARGET: target_ff <= csr_chan.data[TGT_W-1:0];
            REG_KP:     kp_ff     <= csr_chan.data[GAIN_W-1:0];
            REG_KI:     ki_ff     <= csr_chan.data[GAIN_W-1:0];
            REG_KD:     kd_ff     <= csr_chan.data[GAIN_W-1:0];
            REG_TS:     ts_ff     <= csr_chan.data[TS_W-1:0];
            REG_LIMIT:  limit_ff  <= csr_chan.data[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   // register view for the datapath
   always_comb begin
      cfg.target         = target_ff;
      cfg.kp             = kp_ff;
      cfg.ki             = ki_ff;
      cfg.kd             = kd_ff;
      cfg.time_step      = ts_ff;
      cfg.limit          = limit_ff;
      cfg.clear_integral = wr && (csr_chan.index == REG_TARGET);
   end

endmodule

// ----- sv/ptc_mul.sv -----
// ----------------------------------------------------------------------------
// ptc_mul
// shared signed multiplier with a registered product
// ----------------------------------------------------------------------------
module ptc_mul import ptc_pkg::*; (
   input  logic                     clock,
   input  logic signed [MA_W-1:0]   mul_a,
   input  logic signed [MB_W-1:0]   mul_b,
   output logic signed [PROD_W-1:0] prod_ff
);

   logic signed [PROD_W-1:0] prod_in;

   // full precision product
   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ----- tb/tb_pid_throttle_controller.sv -----
// ----------------------------------------------------------------------------
// tb_pid_throttle_controller
// self-checking bench for the pid throttle governor
// ----------------------------------------------------------------------------
// Speed samples go in on req_chan and throttle commands come back on rsp_chan.
// Each command is checked against a bit-exact governor model kept in this
// bench. A short directed run covers the disabled case, the gain, time step
// and limit extremes, a zero time step, a zero integral limit, register
// masking and writes to indexes past the register list. Random phases then
// reprogram the registers and send walks around the target mixed with noise,
// under several idle and stall patterns and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_pid_throttle_controller import ptc_pkg::*; ();

   localparam int RPM_MAX        = (1 << RPM_W) - 1;
   localparam int TARGET_TOP     = 320000;
   localparam int RESET_CYCLES   = 12;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 16;
   localparam int PHASE_ITEMS    = 120;
   localparam int PHASE_COUNT    = 10;
   localparam int PRESSURE_PHASE = 4;

   // indexes past the end of the register list
   localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
   localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;

   typedef enum logic [1:0] {
      PACE_FULL,
      PACE_SENDER_IDLE,
      PACE_RECEIVER_STALL,
      PACE_BOTH
   } pace_type;

   logic clock;
   logic reset;

   ptc_req_if req_chan ();
   ptc_rsp_if rsp_chan ();
   ptc_csr_if csr_chan ();

   pid_throttle_controller dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // governor registers and state as the bench expects them
   longint tgt_rpm;
   longint gain_p;
   longint gain_i;
   longint gain_d;
   longint step_q16;
   longint clamp_rpm_s;
   longint integral_acc;
   longint last_error;
   bit     integral_fresh;

   logic [RPM_W-1:0] samples_pending[$];
   logic [CMD_W-1:0] throttle_expected[$];

   pace_type pace;
   bit       hold_requested;
   int       hold_count;
   bit       hold_finished;
   int       items_sent;
   int       results_checked;
   int       mismatches;
   int       quiet_cycles;

   // one governor update, mirrors the block bit for bit
   function automatic logic [CMD_W-1:0] governor_step(input logic [RPM_W-1:0] measured);
      longint err;
      longint bound;
      longint acc;
      longint sum;
      if (tgt_rpm == 0)
         return '0;
      err = tgt_rpm - longint'(measured);
      if (integral_fresh) begin
         integral_acc   = 0;
         integral_fresh = 1'b0;
      end
      bound = clamp_rpm_s * (longint'(1) <<< INT_FRAC);
      acc   = integral_acc + err * step_q16;
      if (acc > bound)
         acc = bound;
      if (acc < -bound)
         acc = -bound;
      integral_acc = acc;
      sum = gain_p * err * 65536
          + gain_i * integral_acc
          + gain_d * (err - last_error) * 65536;
      last_error = err;
      if (sum <= 0)
         return '0;
      if (sum >= (longint'(1) <<< SUM_ONE_BIT))
         return OUT_FULL;
      return CMD_W'(sum >>> OUT_SHIFT);
   endfunction

   // register write, model updated at the accepting edge
   task automatic write_register(input logic [IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      case (idx)
         REG_TARGET: begin
            tgt_rpm      = value[TGT_W-1:0];
            integral_acc = 0;
         end
         REG_KP:    gain_p      = value[GAIN_W-1:0];
         REG_KI:    gain_i      = value[GAIN_W-1:0];
         REG_KD:    gain_d      = value[GAIN_W-1:0];
         REG_TS:    step_q16    = value[TS_W-1:0];
         REG_LIMIT: clamp_rpm_s = value[LIM_W-1:0];
         default: ;
      endcase
      csr_chan.valid <= 1'b0;
   endtask

   task automatic queue_sample(input logic [RPM_W-1:0] measured);
      samples_pending.push_back(measured);
      items_sent++;
   endtask

   // extreme or random value of a register, junk above its width
   function automatic logic [CSR_DATA_W-1:0] random_field(input int field_w);
      logic [CSR_DATA_W-1:0] v;
      case ($urandom_range(5))
         0:       v = '0;
         1:       v = CSR_DATA_W'((1 << field_w) - 1);
         default: v = CSR_DATA_W'($urandom_range(0, (1 << $urandom_range(1, field_w)) - 1));
      endcase
      v = v | CSR_DATA_W'($urandom() << field_w);
      return v;
   endfunction

   // random walk around the target with noise and extremes mixed in
   task automatic queue_phase_samples(input int count);
      int walk;
      int stride;
      int pick;
      walk   = int'(tgt_rpm);
      stride = 1 << $urandom_range(0, 16);
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            walk = walk + $urandom_range(0, 2 * stride) - stride;
            if (walk < 0)
               walk = 0;
            if (walk > RPM_MAX)
               walk = RPM_MAX;
            queue_sample(walk[RPM_W-1:0]);
         end else if (pick < 85) begin
            queue_sample(RPM_W'($urandom_range(0, RPM_MAX)));
         end else begin
            case ($urandom_range(2))
               0:       queue_sample('0);
               1:       queue_sample(RPM_W'(RPM_MAX));
               default: queue_sample(RPM_W'(tgt_rpm));
            endcase
         end
      end
   endtask

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // sample driver
   always @(posedge clock) begin : sample_driver
      bit rests;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            throttle_expected.push_back(governor_step(req_chan.measured_rpm));
         if (!req_chan.valid || req_chan.ready) begin
            rests = (pace == PACE_SENDER_IDLE && $urandom_range(99) < 86) ||
                    (pace == PACE_BOTH && $urandom_range(99) < 21);
            if (samples_pending.size() != 0 && !rests) begin
               req_chan.valid        <= 1'b1;
               req_chan.measured_rpm <= samples_pending.pop_front();
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // command monitor and receiver pacing
   always @(posedge clock) begin : command_monitor
      logic [CMD_W-1:0] want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (throttle_expected.size() == 0) begin
               $error("throttle_cmd unexpected item, actual %0d", rsp_chan.throttle_cmd);
               mismatches++;
            end else begin
               want = throttle_expected.pop_front();
               if (rsp_chan.throttle_cmd !== want) begin
                  $error("throttle_cmd expected %0d actual %0d", want, rsp_chan.throttle_cmd);
                  mismatches++;
               end
               results_checked++;
            end
         end
         // long hold-off so the block backs up into the sample channel
         if (hold_requested && !hold_finished) begin
            rsp_chan.ready <= 1'b0;
            hold_count++;
            if (hold_count >= HOLD_CYCLES)
               hold_finished = 1'b1;
         end else begin
            rsp_chan.ready <= !((pace == PACE_RECEIVER_STALL && $urandom_range(99) < 86) ||
                                (pace == PACE_BOTH && $urandom_range(99) < 21));
         end
      end
   end

   // watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // stimulus sequence
   initial begin
      clock                 = 1'b0;
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.measured_rpm = '0;
      rsp_chan.ready        = 1'b0;
      csr_chan.valid        = 1'b0;
      csr_chan.index        = REG_TARGET;
      csr_chan.data         = '0;
      pace                  = PACE_FULL;
      hold_requested        = 1'b0;
      hold_count            = 0;
      hold_finished         = 1'b0;
      items_sent            = 0;
      results_checked       = 0;
      mismatches            = 0;
      quiet_cycles          = 0;
      tgt_rpm               = RST_TARGET;
      gain_p                = RST_KP;
      gain_i                = RST_KI;
      gain_d                = RST_KD;
      step_q16              = RST_TS;
      clamp_rpm_s           = RST_LIMIT;
      integral_acc          = 0;
      last_error            = 0;
      integral_fresh        = 1'b1;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // control disabled out of reset
      queue_sample('0);
      queue_sample(RPM_W'(RPM_MAX));
      wait (results_checked == items_sent);

      // default gains, target set to TARGET_TOP
      write_register(REG_TARGET, CSR_DATA_W'(TARGET_TOP));
      queue_sample(RPM_W'(TARGET_TOP));
      queue_sample('0);
      queue_sample(RPM_W'(RPM_MAX));
      queue_sample(RPM_W'(TARGET_TOP - 1));
      wait (results_checked == items_sent);

      // all gains zero
      write_register(REG_KP, '0);
      write_register(REG_KI, '0);
      write_register(REG_KD, '0);
      queue_sample('0);
      wait (results_checked == items_sent);

      // smallest kp, largest ki, kd, time step and limit
      write_register(REG_KP, 24'd1);
      write_register(REG_KI, 24'hFFFFFF);
      write_register(REG_KD, 24'hFFFFFF);
      write_register(REG_TS, 24'h00FFFF);
      write_register(REG_LIMIT, 24'h00FFFF);
      queue_sample(RPM_W'(TARGET_TOP - 10));
      queue_sample(RPM_W'(TARGET_TOP + 10));
      queue_sample('0);
      queue_sample(RPM_W'(TARGET_TOP));
      wait (results_checked == items_sent);

      // zero time step, then zero integral limit
      write_register(REG_KP, 24'd16);
      write_register(REG_KI, 24'd65536);
      write_register(REG_KD, 24'd4);
      write_register(REG_TS, '0);
      queue_sample(RPM_W'(TARGET_TOP - 100));
      queue_sample(RPM_W'(TARGET_TOP - 200));
      wait (results_checked == items_sent);
      write_register(REG_TS, 24'd30000);
      write_register(REG_LIMIT, '0);
      queue_sample(RPM_W'(TARGET_TOP - 300));
      queue_sample(RPM_W'(TARGET_TOP + 300));
      wait (results_checked == items_sent);

      // spare indexes ignored, bits above the target width dropped
      write_register(REG_SPARE_A, 24'hFFFFFF);
      write_register(REG_SPARE_B, 24'h123456);
      write_register(REG_LIMIT, 24'hFF0100);
      write_register(REG_TARGET, 24'hFFFFFF);
      queue_sample(RPM_W'(RPM_MAX));
      queue_sample('0);
      queue_sample(RPM_W'(RPM_MAX - 5));
      wait (results_checked == items_sent);

      // disabled again mid-run, state must survive
      write_register(REG_TARGET, '0);
      queue_sample(RPM_W'(12345));
      wait (results_checked == items_sent);

      // random phases under each pacing pattern
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         pace = pace_type'(phase % 4);
         if (phase == 0 || $urandom_range(3) != 0)
            write_register(REG_KP, random_field(GAIN_W));
         if (phase == 0 || $urandom_range(3) != 0)
            write_register(REG_KI, random_field(GAIN_W));
         if (phase == 0 || $urandom_range(3) != 0)
            write_register(REG_KD, random_field(GAIN_W));
         if (phase == 0 || $urandom_range(3) != 0)
            write_register(REG_TS, random_field(TS_W));
         if (phase == 0 || $urandom_range(3) != 0)
            write_register(REG_LIMIT, random_field(LIM_W));
         if (phase == 0 || $urandom_range(3) != 0) begin
            case ($urandom_range(7))
               0:       write_register(REG_TARGET, CSR_DATA_W'(TARGET_TOP));
               1:       write_register(REG_TARGET, CSR_DATA_W'(RPM_MAX));
               2:       write_register(REG_TARGET, CSR_DATA_W'(1));
               default: write_register(REG_TARGET,
                           CSR_DATA_W'($urandom_range(1, TARGET_TOP)) |
                           CSR_DATA_W'($urandom() << TGT_W));
            endcase
         end
         if (phase == PRESSURE_PHASE)
            hold_requested = 1'b1;
         queue_phase_samples(PHASE_ITEMS);
         wait (results_checked == items_sent);
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && throttle_expected.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
